// ----- rtl/rht_pkg.sv -----
`default_nettype none
package rht_pkg;

    localparam int OP_FIELD_LEN    = 16;
    localparam int NAME_FIELD_LEN  = 256;
    localparam int DIGIT_FIELD_LEN = 32;

    localparam int IDX_MAX_A = (OP_FIELD_LEN > NAME_FIELD_LEN) ? OP_FIELD_LEN : NAME_FIELD_LEN;
    localparam int IDX_MAX   = (IDX_MAX_A > DIGIT_FIELD_LEN) ? IDX_MAX_A : DIGIT_FIELD_LEN;
    localparam int IDX_W     = $clog2(IDX_MAX);

    localparam int LEN_W = 64;

    localparam logic [1:0] SRC_VALID = 2'd0;
    localparam logic [1:0] SRC_ENDED = 2'd1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [1:0] SEP_LAST = 2'd3;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ENDED      = 3'd1,
        ST_TOO_MANY   = 3'd2,
        ST_READ_FAIL  = 3'd3,
        ST_ZERO_LEN   = 3'd4,
        ST_OP_LONG    = 3'd5,
        ST_NAME_LONG  = 3'd6,
        ST_DIGIT_LONG = 3'd7
    } t_status;

    typedef struct packed {
        t_kind             kind;
        logic [1:0]        field;
        logic [7:0]        pos;
        logic [7:0]        chr;
        logic [LEN_W-1:0]  len;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic feed;
        logic clear;
    } t_num_ctl;

endpackage
`default_nettype wire

// ----- rtl/rht_if.sv -----
`default_nettype none
interface rht_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic [1:0] source_status;

    modport source (output valid, output header_byte, output source_status, input ready);
    modport sink (input valid, input header_byte, input source_status, output ready);
endinterface

interface rht_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic [1:0]         field_number;
    logic [7:0]         char_position;
    logic [7:0]         char_value;
    logic signed [63:0] length_value;
    logic [2:0]         status_code;

    modport source (output valid, output result_kind, output field_number,
                    output char_position, output char_value, output length_value,
                    output status_code, input ready);
    modport sink (input valid, input result_kind, input field_number,
                  input char_position, input char_value, input length_value,
                  input status_code, output ready);
endinterface
`default_nettype wire

// ----- rtl/rht_number.sv -----
`default_nettype none
module rht_number (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire rht_pkg::t_num_ctl        i_ctl,
    input  wire logic [7:0]               i_byte,
    output logic [rht_pkg::LEN_W-1:0]     o_len,
    output logic                          o_zero
);
    localparam int PW = rht_pkg::LEN_W + 4;

    logic [rht_pkg::LEN_W-1:0] r_acc, n_acc;
    logic                      r_neg, n_neg;
    logic                      r_stop, n_stop;
    logic                      r_begun, n_begun;

    logic                      is_blank;
    logic                      is_digit;
    logic [PW-1:0]             wide_acc;
    logic [PW-1:0]             prod;
    logic [rht_pkg::LEN_W-1:0] limit;

    assign is_blank = (i_byte == rht_pkg::CH_TAB) || (i_byte == rht_pkg::CH_VT) ||
                      (i_byte == rht_pkg::CH_FF)  || (i_byte == rht_pkg::CH_CR);
    assign is_digit = (i_byte inside {[rht_pkg::CH_0:rht_pkg::CH_9]});

    // acc*10 + d; saturate when it passes the signed limit
    assign wide_acc = {4'b0, r_acc};
    assign prod     = (wide_acc << 3) + (wide_acc << 1) +
                      PW'(i_byte - rht_pkg::CH_0) ;
    assign limit    = {1'b1, {(rht_pkg::LEN_W-1){1'b0}}} -
                      rht_pkg::LEN_W'(!r_neg);

    always_comb begin
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_stop  = r_stop;
        n_begun = r_begun;
        if (i_ctl.clear) begin
            n_acc   = '0;
            n_neg   = 1'b0;
            n_stop  = 1'b0;
            n_begun = 1'b0;
        end else if (i_ctl.feed && !r_stop) begin
            if (!(r_begun == 1'b0 && is_blank)) begin
                n_begun = 1'b1;
                if (!r_begun && i_byte == rht_pkg::CH_PLUS) begin
                    n_begun = 1'b1;
                end else if (!r_begun && i_byte == rht_pkg::CH_MINUS) begin
                    n_neg = 1'b1;
                end else if (is_digit) begin
                    if (prod > {4'b0, limit}) begin
                        n_acc = limit;
                    end else begin
                        n_acc = prod[rht_pkg::LEN_W-1:0];
                    end
                end else begin
                    n_stop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_stop  <= 1'b0;
            r_begun <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_stop  <= n_stop;
            r_begun <= n_begun;
        end
    end

    assign o_len  = r_neg ? ('0 - r_acc) : r_acc;
    assign o_zero = (r_acc == '0);
endmodule
`default_nettype wire

// ----- rtl/rht_parse.sv -----
`default_nettype none
module rht_parse (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    input  wire logic [1:0]       i_src,
    output rht_pkg::t_result      o_res,
    output logic                  o_has
);
    localparam int IW = rht_pkg::IDX_W;

    logic [1:0]    r_sep, n_sep;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW:0]   idx_inc;
    logic [IW+7:0] idx_ext;
    logic          restart;
    logic          feed;

    rht_pkg::t_num_ctl         num_ctl;
    logic [rht_pkg::LEN_W-1:0] num_len;
    logic                      num_zero;

    assign idx_inc = {1'b0, r_idx} + (IW+1)'(1);
    assign idx_ext = {8'b0, r_idx};

    always_comb begin
        o_res   = '0;
        o_has   = 1'b0;
        restart = 1'b0;
        feed    = 1'b0;
        n_sep   = r_sep;
        n_idx   = r_idx;
        if (i_src == rht_pkg::SRC_ENDED) begin
            o_has        = 1'b1;
            o_res.kind   = rht_pkg::KIND_ERROR;
            o_res.status = rht_pkg::ST_ENDED;
        end else if (i_src != rht_pkg::SRC_VALID) begin
            o_has        = 1'b1;
            o_res.kind   = rht_pkg::KIND_ERROR;
            o_res.status = rht_pkg::ST_READ_FAIL;
        end else if (i_byte == rht_pkg::CH_NUL) begin
            o_has = 1'b0;
        end else if (i_byte == rht_pkg::CH_NL) begin
            o_has = 1'b1;
            if (r_sep == rht_pkg::SEP_LAST && num_zero) begin
                o_res.kind   = rht_pkg::KIND_ERROR;
                o_res.status = rht_pkg::ST_ZERO_LEN;
            end else begin
                o_res.kind = rht_pkg::KIND_DONE;
                o_res.len  = (r_sep == rht_pkg::SEP_LAST) ? num_len : '0;
            end
        end else if (i_byte == rht_pkg::CH_SP) begin
            if (r_sep == rht_pkg::SEP_LAST) begin
                o_has        = 1'b1;
                o_res.kind   = rht_pkg::KIND_ERROR;
                o_res.status = rht_pkg::ST_TOO_MANY;
            end else begin
                n_sep = r_sep + 2'd1;
                n_idx = '0;
            end
        end else begin
            case (r_sep)
                2'd0: begin
                    o_has = 1'b1;
                    if (idx_inc >= (IW+1)'(rht_pkg::OP_FIELD_LEN)) begin
                        o_res.kind   = rht_pkg::KIND_ERROR;
                        o_res.status = rht_pkg::ST_OP_LONG;
                    end else begin
                        o_res.kind = rht_pkg::KIND_CHAR;
                        o_res.pos  = idx_ext[7:0];
                        o_res.chr  = i_byte;
                        n_idx      = idx_inc[IW-1:0];
                    end
                end
                2'd1: begin
                    o_has = 1'b1;
                    if (idx_inc >= (IW+1)'(rht_pkg::NAME_FIELD_LEN)) begin
                        o_res.kind   = rht_pkg::KIND_ERROR;
                        o_res.status = rht_pkg::ST_NAME_LONG;
                    end else begin
                        o_res.kind  = rht_pkg::KIND_CHAR;
                        o_res.field = 2'd1;
                        o_res.pos   = idx_ext[7:0];
                        o_res.chr   = i_byte;
                        n_idx       = idx_inc[IW-1:0];
                    end
                end
                2'd2: begin
                    feed = 1'b1;
                    if (idx_inc >= (IW+1)'(rht_pkg::DIGIT_FIELD_LEN)) begin
                        o_has        = 1'b1;
                        o_res.kind   = rht_pkg::KIND_ERROR;
                        o_res.status = rht_pkg::ST_DIGIT_LONG;
                    end else begin
                        n_idx = idx_inc[IW-1:0];
                    end
                end
                default: begin
                    o_has = 1'b0;
                end
            endcase
        end
        if (o_has && o_res.kind != rht_pkg::KIND_CHAR) begin
            restart = 1'b1;
            n_sep   = '0;
            n_idx   = '0;
        end
    end

    assign num_ctl.feed  = feed & i_step;
    assign num_ctl.clear = restart & i_step;

    rht_number u_number (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (num_ctl),
        .i_byte  (i_byte),
        .o_len   (num_len),
        .o_zero  (num_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= '0;
            r_idx <= '0;
        end else if (i_step) begin
            r_sep <= n_sep;
            r_idx <= n_idx;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/request_header_tokenizer_top.sv -----
`default_nettype none
// Request header tokenizer. Takes one header byte per cycle when the output is
// not stalled and returns at most one result per byte: a stored character of the
// operation or name field, a header-complete result with the parsed length, or
// an error; after a complete or error result the parser restarts at a fresh
// line. A byte is registered on acceptance and parsed into the output register
// when the output can advance, so a result passes through the input and output
// registers; with the output taken every cycle the block sustains one byte per
// cycle. Bytes that give no result (NUL, separators, length digits) still take a parse step.
module request_header_tokenizer_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rht_in_if.sink     i_hdr,
    rht_out_if.source  o_res
);
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic [1:0] r_src;

    logic             r_out_valid;
    rht_pkg::t_result r_res;

    logic             advance;
    logic             has;
    rht_pkg::t_result res;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_hdr.ready = i_rst_n && (!r_in_valid || advance);

    rht_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_byte),
        .i_src   (r_src),
        .o_res   (res),
        .o_has   (has)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_hdr.ready) begin
                r_in_valid <= i_hdr.valid;
            end
            if (advance) begin
                r_out_valid <= has;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_hdr.valid && i_hdr.ready) begin
            r_byte <= i_hdr.header_byte;
            r_src  <= i_hdr.source_status;
        end
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.result_kind   = r_res.kind;
    assign o_res.field_number  = r_res.field;
    assign o_res.char_position = r_res.pos;
    assign o_res.char_value    = r_res.chr;
    assign o_res.length_value  = r_res.len;
    assign o_res.status_code   = r_res.status;
endmodule
`default_nettype wire

// ----- rtl/rht_checker.sv -----
`default_nettype none
module rht_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  i_kind,
    input wire logic [1:0]  i_field,
    input wire logic [7:0]  i_pos,
    input wire logic [7:0]  i_chr,
    input wire logic [63:0] i_len,
    input wire logic [2:0]  i_status
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_len) &&
        $stable(i_status) && $stable(i_chr) && $stable(i_pos))
        else $error("result changed while stalled");

    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == rht_pkg::KIND_CHAR |->
        i_len == '0 && i_status == rht_pkg::ST_OK && (i_field == 2'd0 || i_field == 2'd1))
        else $error("character result carries length or status");

    a_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != rht_pkg::KIND_CHAR |->
        i_field == '0 && i_pos == '0 && i_chr == '0 &&
        (i_kind == rht_pkg::KIND_DONE || i_kind == rht_pkg::KIND_ERROR))
        else $error("bad control result");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == rht_pkg::KIND_ERROR |-> i_len == '0 && i_status != rht_pkg::ST_OK)
        else $error("error result without status");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == rht_pkg::KIND_DONE |-> i_status == rht_pkg::ST_OK)
        else $error("complete result with status");
endmodule

bind request_header_tokenizer_top rht_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_kind   (o_res.result_kind),
    .i_field  (o_res.field_number),
    .i_pos    (o_res.char_position),
    .i_chr    (o_res.char_value),
    .i_len    (o_res.length_value),
    .i_status (o_res.status_code)
);
`default_nettype wire
